FILE: rtl/gss_pkg.sv
`default_nettype none
package gss_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int FIELD_W     = 32;
    localparam int TOL_W       = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_BOUND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE   = 2'd2;

    localparam logic [FIELD_W-1:0] LOWER_BOUND_RST = 32'sd0;
    localparam logic [FIELD_W-1:0] UPPER_BOUND_RST = 32'sd205887;
    localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 31'd1;

    localparam logic [63:0] GOLD_LO32 = 64'd1640531527;
    localparam logic [63:0] GOLD_HI32 = 64'd2654435769;

    // Rounds a 32-bit fraction to the given number of fraction bits.
    function automatic logic [63:0] golden_round(input logic [63:0] gold,
                                                 input int unsigned frac);
        int unsigned sh;
        sh = 32 - frac;
        return (gold + ((64'd1 << sh) >> 1)) >> sh;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gss_in_if.sv
`default_nettype none
interface gss_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink (input valid, input func, input sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/gss_out_if.sv
`default_nettype none
interface gss_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point;
    logic               done_res;
    logic               misuse;

    modport source (output valid, output point, output done_res, output misuse, input ready);
    modport sink (input valid, input point, input done_res, input misuse, output ready);
endinterface
`default_nettype wire

FILE: rtl/gss_scale.sv
`default_nettype none
module gss_scale #(
    parameter int COORD_WIDTH = gss_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = gss_pkg::FRAC_BITS_DEF,
    parameter logic [FRAC_BITS-1:0] RATIO = '0
) (
    input  wire logic [COORD_WIDTH-1:0] i_len,
    output logic      [COORD_WIDTH-1:0] o_part
);
    import gss_pkg::*;

    logic [COORD_WIDTH+FRAC_BITS-1:0] prod;

    assign prod   = (COORD_WIDTH+FRAC_BITS)'(i_len) * (COORD_WIDTH+FRAC_BITS)'(RATIO);
    assign o_part = prod[COORD_WIDTH+FRAC_BITS-1:FRAC_BITS];

endmodule
`default_nettype wire

FILE: rtl/golden_section_minimum_search.sv
// An item is captured in the input register and its result in the output register.
// Throughput: one item per cycle while the output is accepted; the bracket update,
// the constant-ratio multiply and the stopping tests all sit in the single stage
// after the input register. Reset: synchronous and active low; the search goes idle
// and the configuration registers return to their default bracket and tolerance.
`default_nettype none
module golden_section_minimum_search #(
    parameter int COORD_WIDTH  = gss_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS    = gss_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH = gss_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [gss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gss_in_if.sink                               i_in,
    gss_out_if.source                            o_out
);
    import gss_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int SW = SAMPLE_WIDTH;
    localparam logic [FRAC_BITS-1:0] RATIO_LO = FRAC_BITS'(golden_round(GOLD_LO32, FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] RATIO_HI = FRAC_BITS'(golden_round(GOLD_HI32, FRAC_BITS));

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_FIRST_L = 3'd1;
    localparam logic [2:0] PH_FIRST_R = 3'd2;
    localparam logic [2:0] PH_NEXT_L  = 3'd3;
    localparam logic [2:0] PH_NEXT_R  = 3'd4;

    logic signed [FIELD_W-1:0] r_lower_bound;
    logic signed [FIELD_W-1:0] r_upper_bound;
    logic [TOL_W-1:0]          r_tolerance;

    logic [CW-1:0] r_left, r_right, r_il, r_ir;
    logic [CW-1:0] n_left, n_right, n_il, n_ir;
    logic [SW-1:0] r_vl, r_vr, n_vl, n_vr;
    logic [2:0]    r_phase, n_phase;

    logic               r_in_valid;
    logic               r_in_func;
    logic [FIELD_W-1:0] r_in_sample;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_point, n_out_point;
    logic               r_out_done, n_out_done;
    logic               r_out_misuse, n_out_misuse;

    logic          adv;
    logic          start;
    logic [SW-1:0] smp, eff_vl, eff_vr;
    logic          pick_left;
    logic [CW-1:0] cfg_left, cfg_right, cfg_len;
    logic [CW-1:0] len, upd_left, upd_right, nlen;
    logic [CW-1:0] mlen, mbase, scl_lo, scl_hi, cand_lo, cand_hi;
    logic          tol_stop, stall;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || !r_out_valid || o_out.ready;

    assign start     = !r_in_func;
    assign smp       = SW'(r_in_sample);
    assign eff_vl    = (r_phase == PH_NEXT_L) ? smp : r_vl;
    assign eff_vr    = (r_phase == PH_FIRST_R || r_phase == PH_NEXT_R) ? smp : r_vr;
    assign pick_left = $signed(eff_vl) <= $signed(eff_vr);

    assign cfg_left  = CW'(r_lower_bound);
    assign cfg_right = CW'(r_upper_bound);
    assign cfg_len   = cfg_right - cfg_left;

    assign len       = r_right - r_left;
    assign upd_left  = pick_left ? r_left : r_il;
    assign upd_right = pick_left ? r_ir : r_right;
    assign nlen      = upd_right - upd_left;
    assign tol_stop  = 64'(len >> 1) < 64'(r_tolerance);
    assign stall     = nlen >= len;

    assign mlen    = start ? cfg_len : nlen;
    assign mbase   = start ? cfg_left : upd_left;
    assign cand_lo = mbase + scl_lo;
    assign cand_hi = mbase + scl_hi;

    gss_scale #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .RATIO       (RATIO_LO)
    ) u_scale_lo (
        .i_len  (mlen),
        .o_part (scl_lo)
    );

    gss_scale #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .RATIO       (RATIO_HI)
    ) u_scale_hi (
        .i_len  (mlen),
        .o_part (scl_hi)
    );

    always_comb begin
        n_left       = r_left;
        n_right      = r_right;
        n_il         = r_il;
        n_ir         = r_ir;
        n_vl         = r_vl;
        n_vr         = r_vr;
        n_phase      = r_phase;
        n_out_point  = '0;
        n_out_done   = 1'b0;
        n_out_misuse = 1'b0;
        if (start) begin
            n_left      = cfg_left;
            n_right     = cfg_right;
            n_il        = cand_lo;
            n_ir        = cand_hi;
            n_phase     = PH_FIRST_L;
            n_out_point = FIELD_W'(cand_lo);
        end else begin
            unique case (r_phase) inside
                PH_FIRST_L: begin
                    n_vl        = smp;
                    n_phase     = PH_FIRST_R;
                    n_out_point = FIELD_W'(r_ir);
                end
                PH_FIRST_R, PH_NEXT_R, PH_NEXT_L: begin
                    n_vl = eff_vl;
                    n_vr = eff_vr;
                    if (tol_stop) begin
                        n_phase     = PH_IDLE;
                        n_out_point = FIELD_W'(r_left + (len >> 1));
                        n_out_done  = 1'b1;
                    end else begin
                        if (pick_left) begin
                            n_right     = r_ir;
                            n_ir        = r_il;
                            n_vr        = eff_vl;
                            n_il        = cand_lo;
                            n_phase     = PH_NEXT_L;
                            n_out_point = FIELD_W'(cand_lo);
                        end else begin
                            n_left      = r_il;
                            n_il        = r_ir;
                            n_vl        = eff_vr;
                            n_ir        = cand_hi;
                            n_phase     = PH_NEXT_R;
                            n_out_point = FIELD_W'(cand_hi);
                        end
                        if (stall) begin
                            n_phase     = PH_IDLE;
                            n_out_point = FIELD_W'(upd_left + (nlen >> 1));
                            n_out_done  = 1'b1;
                        end
                    end
                end
                default: begin
                    n_out_misuse = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= LOWER_BOUND_RST;
            r_upper_bound <= UPPER_BOUND_RST;
            r_tolerance   <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWER_BOUND: r_lower_bound <= i_cfg_data;
                CFG_UPPER_BOUND: r_upper_bound <= i_cfg_data;
                CFG_TOLERANCE:   r_tolerance   <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_func   <= i_in.func;
            r_in_sample <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_il    <= n_il;
            r_ir    <= n_ir;
            r_vl    <= n_vl;
            r_vr    <= n_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_point  <= n_out_point;
            r_out_done   <= n_out_done;
            r_out_misuse <= n_out_misuse;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.point    = r_out_point;
    assign o_out.done_res = r_out_done;
    assign o_out.misuse   = r_out_misuse;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gss_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_LIMIT = 30;

    // Golden ratios rounded from the 32-bit fractions to 16 fraction bits.
    localparam logic [63:0] RATIO_LO = (GOLD_LO32 + 64'd32768) >> 16;
    localparam logic [63:0] RATIO_HI = (GOLD_HI32 + 64'd32768) >> 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIRST_L,
        PH_FIRST_R,
        PH_NEXT_L,
        PH_NEXT_R
    } t_search_phase;

    typedef struct packed {
        logic [31:0] point;
        logic        done_res;
        logic        misuse;
    } t_result;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_INDEX_W-1:0]   idx;
        logic [31:0]              data;
        logic                     fn;
        bit                       fixed;
        t_result                  want;
    } t_row;

    localparam t_result R_ZERO_PROBE = '{point: 32'd0, done_res: 1'b0, misuse: 1'b0};
    localparam t_result R_ZERO_FINAL = '{point: 32'd0, done_res: 1'b1, misuse: 1'b0};
    localparam t_result R_MISUSE     = '{point: 32'd0, done_res: 1'b0, misuse: 1'b1};

    localparam int N_ROWS = 34;

    // The register index is ignored on item rows.
    t_row dir_rows [0:N_ROWS-1] = '{
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h7FFF_FFFF, 1'b1, 1'b1, R_MISUSE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h8000_0000, 1'b1, 1'b1, R_MISUSE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'hFFFF_FFFF, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0064, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0064, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h8000_0000, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h7FFF_FFFF, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0005, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_LOWER_BOUND, 32'h0000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_UPPER_BOUND, 32'h0000_0001, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0000, 1'b0, 1'b1, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'hFFFF_FFFD, 1'b1, 1'b1, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0007, 1'b1, 1'b1, R_ZERO_FINAL},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0001, 1'b1, 1'b1, R_MISUSE},
        '{ROW_CFG,  CFG_LOWER_BOUND, 32'h8000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_UPPER_BOUND, 32'h7FFF_FFFF, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_TOLERANCE,   32'h7FFF_FFFF, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'hAAAA_AAAA, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h5555_5555, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h5555_5555, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_LOWER_BOUND, 32'h0064_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_UPPER_BOUND, 32'hFF9C_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_TOLERANCE,   32'h0000_0001, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0001, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0002, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_TOLERANCE,   32'h0000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_LOWER_BOUND, 32'h0000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_CFG,  CFG_UPPER_BOUND, 32'h0001_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0000, 1'b0, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0003, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0002, 1'b1, 1'b0, R_ZERO_PROBE},
        '{ROW_ITEM, CFG_LOWER_BOUND, 32'h0000_0001, 1'b1, 1'b0, R_ZERO_PROBE}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    gss_in_if  in_if ();
    gss_out_if out_if ();

    golden_section_minimum_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow of the configuration and of the search state.
    logic [31:0]        cfg_lower = LOWER_BOUND_RST;
    logic [31:0]        cfg_upper = UPPER_BOUND_RST;
    logic [30:0]        cfg_tol   = TOLERANCE_RST;
    logic [31:0]        brk_lo    = '0;
    logic [31:0]        brk_hi    = '0;
    logic [31:0]        probe_l   = '0;
    logic [31:0]        probe_r   = '0;
    logic signed [31:0] val_l     = '0;
    logic signed [31:0] val_r     = '0;
    t_search_phase      srch_phase = PH_IDLE;

    t_result     pending_results [$];
    logic [31:0] last_probe  = '0;
    logic [31:0] last_sample = '0;
    logic [31:0] target      = '0;
    bit          src_on      = 1'b0;
    int          burst_left  = 0;
    int          n_err       = 0;
    int          n_useful    = 0;
    int          n_final     = 0;
    int          n_misuse    = 0;
    int          n_settings  = 0;
    int          cyc         = 0;

    function automatic logic [31:0] golden_offset(input logic [31:0] len,
                                                  input logic [63:0] ratio);
        logic [63:0] prod;
        prod = {32'd0, len} * ratio;
        return prod[47:16];
    endfunction

    function automatic t_result close_search();
        t_result r;
        r = R_ZERO_FINAL;
        r.point = brk_lo + ((brk_hi - brk_lo) >> 1);
        srch_phase = PH_IDLE;
        return r;
    endfunction

    function automatic t_result narrow_bracket();
        logic [31:0] len;
        logic [31:0] nlen;
        t_result     r;
        r = R_ZERO_PROBE;
        len = brk_hi - brk_lo;
        if ((len >> 1) < {1'b0, cfg_tol}) begin
            return close_search();
        end
        // On equal samples the left part of the bracket is kept.
        if (val_l <= val_r) begin
            brk_hi = probe_r;
            probe_r = probe_l;
            val_r = val_l;
            nlen = brk_hi - brk_lo;
            probe_l = brk_lo + golden_offset(nlen, RATIO_LO);
            srch_phase = PH_NEXT_L;
            r.point = probe_l;
        end else begin
            brk_lo = probe_l;
            probe_l = probe_r;
            val_l = val_r;
            nlen = brk_hi - brk_lo;
            probe_r = brk_lo + golden_offset(nlen, RATIO_HI);
            srch_phase = PH_NEXT_R;
            r.point = probe_r;
        end
        if (nlen >= len) begin
            r = close_search();
        end
        return r;
    endfunction

    function automatic t_result next_probe(input logic fn, input logic [31:0] smp);
        t_result r;
        r = R_ZERO_PROBE;
        if (!fn) begin
            brk_lo = cfg_lower;
            brk_hi = cfg_upper;
            probe_l = brk_lo + golden_offset(brk_hi - brk_lo, RATIO_LO);
            probe_r = brk_lo + golden_offset(brk_hi - brk_lo, RATIO_HI);
            srch_phase = PH_FIRST_L;
            r.point = probe_l;
        end else begin
            case (srch_phase)
                PH_FIRST_L: begin
                    val_l = smp;
                    srch_phase = PH_FIRST_R;
                    r.point = probe_r;
                end
                PH_FIRST_R, PH_NEXT_R: begin
                    val_r = smp;
                    r = narrow_bracket();
                end
                PH_NEXT_L: begin
                    val_l = smp;
                    r = narrow_bracket();
                end
                default: begin
                    r = R_MISUSE;
                end
            endcase
        end
        return r;
    endfunction

    // Mostly a bowl around the target, with flat runs, extremes and noise mixed in.
    function automatic logic [31:0] pick_sample();
        logic signed [31:0] d;
        int                 sel;
        sel = $urandom_range(0, 99);
        d = $signed(last_probe - target);
        if (sel < 60) begin
            return (d < 0) ? -d : d;
        end else if (sel < 70) begin
            return last_sample;
        end else if (sel < 80) begin
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_err++;
        if (n_err <= PRINT_LIMIT) begin
            $display("tb_top: %s mismatch, got %h expected %h (cycle %0d)",
                     what, got, want, cyc);
        end
    endtask

    task automatic push_item(input logic fn, input logic [31:0] smp, input bit fixed,
                             input t_result typed);
        t_result r;
        in_if.valid <= 1'b1;
        in_if.func <= fn;
        in_if.sample <= smp;
        src_on = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        r = next_probe(fn, smp);
        pending_results.push_back(fixed ? typed : r);
        last_probe = r.point;
        if (fn) begin
            last_sample = smp;
        end
        if (r.misuse) begin
            n_misuse++;
        end else begin
            n_useful++;
        end
        if (r.done_res) begin
            n_final++;
        end
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_if.valid <= 1'b0;
            src_on = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 40);
        end
    endtask

    // Stops the sender and waits until every outstanding result has been transferred.
    task automatic settle();
        if (src_on) begin
            in_if.valid <= 1'b0;
            src_on = 1'b0;
        end
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOWER_BOUND: cfg_lower = data;
            CFG_UPPER_BOUND: cfg_upper = data;
            CFG_TOLERANCE:   cfg_tol = data[30:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb_top: timed out with %0d results outstanding",
                     pending_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", out_if.point, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.point !== want.point) begin
                    report_mismatch("point", out_if.point, want.point);
                end
                if (out_if.done_res !== want.done_res) begin
                    report_mismatch("done_res", 32'(out_if.done_res), 32'(want.done_res));
                end
                if (out_if.misuse !== want.misuse) begin
                    report_mismatch("misuse", 32'(out_if.misuse), 32'(want.misuse));
                end
            end
        end
    end

    initial begin
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            tick++;
            case (mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom_range(0, 1));
                2: out_if.ready <= (tick % 4 == 0);
                default: out_if.ready <= 1'b0;
            endcase
        end
    end

    initial begin
        int          steps;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span_w;
        logic [31:0] tol;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LOWER_BOUND;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.func = 1'b0;
        in_if.sample = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                push_item(dir_rows[i].fn, dir_rows[i].data, dir_rows[i].fixed,
                          dir_rows[i].want);
            end
        end

        while (n_useful < ITEM_TARGET) begin
            settle();
            lo = $urandom();
            case ($urandom_range(0, 5))
                0: begin
                    hi = lo + $urandom_range(1, 1 << 20);
                    tol = $urandom_range(1, 64);
                end
                1: begin
                    hi = lo + $urandom();
                    tol = $urandom_range(0, 1) ? $urandom_range(1, 1 << 12)
                                               : $urandom_range(1, 32'h7FFF_FFFF);
                end
                2: begin
                    lo = 32'h8000_0000;
                    hi = 32'h7FFF_FFFF;
                    tol = $urandom_range(0, 1) ? 32'd1 : 32'h7FFF_FFFF;
                end
                3: begin
                    hi = lo - $urandom_range(1, 1 << 24);
                    tol = $urandom_range(1, 1024);
                end
                4: begin
                    hi = lo;
                    tol = $urandom_range(1, 8);
                end
                default: begin
                    hi = lo + $urandom_range(0, 16);
                    tol = $urandom_range(0, 2);
                end
            endcase
            write_reg(CFG_LOWER_BOUND, lo);
            write_reg(CFG_UPPER_BOUND, hi);
            write_reg(CFG_TOLERANCE, tol);
            n_settings++;
            span_w = hi - lo;
            steps = $urandom_range(30, 120);
            for (int k = 0; k < steps; k++) begin
                if (k == 0 || (srch_phase == PH_IDLE && $urandom_range(0, 9) != 0)
                        || (srch_phase != PH_IDLE && $urandom_range(0, 39) == 0)) begin
                    target = lo + ((span_w == 0) ? 32'd0 : $urandom() % span_w);
                    push_item(1'b0, $urandom(), 1'b0, R_ZERO_PROBE);
                end else begin
                    push_item(1'b1, pick_sample(), 1'b0, R_ZERO_PROBE);
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("tb_top: %0d items transferred, %0d samples flagged while idle",
                 n_useful + n_misuse, n_misuse);
        $display("tb_top: %0d searches finished over %0d random bracket settings",
                 n_final, n_settings);
        if (n_err == 0 && pending_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
